// ===== src/mqlbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mqlbm_pkg
// Shared constants, codes and item types of the multi-queue buffer manager.
// ----------------------------------------------------------------------------
package mqlbm_pkg;

	localparam int NUM_QUEUES_DEF      = 64;
	localparam int NUM_BUFFERS_DEF     = 1024;
	localparam int PRIORITY_LEVELS_DEF = 8;

	// Operation codes carried by the kind field.
	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_ENQUEUE = 2'd1;
	localparam logic [1:0] OP_DEQUEUE = 2'd2;

	// Queue status encoding.
	localparam logic [1:0] QSTAT_FREE      = 2'd0;
	localparam logic [1:0] QSTAT_UNSCHED   = 2'd1;
	localparam logic [1:0] QSTAT_SCHEDULED = 2'd2;
	localparam logic [1:0] QSTAT_RUNNABLE  = 2'd3;

	// Queue types that matter to scheduling.
	localparam logic [1:0] TYPE_SCHED = 2'd1;
	localparam logic [1:0] TYPE_PKTIN = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic [2:0] DEFAULT_PRIORITY_RST = 3'd4;

	// A request after classification by the front part.
	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] handle;
		logic       handle_ok;
		logic [9:0] buffer_index;
		logic [1:0] new_queue_type;
		logic       param_given;
		logic [2:0] new_priority;
	} item_t;

	typedef struct packed {
		logic [6:0] result_handle;
		logic [9:0] out_buffer;
		logic       out_buffer_valid;
		logic       schedule_request;
		logic [2:0] schedule_priority;
		logic [1:0] addressed_type;
		logic [1:0] op_status;
	} result_t;

endpackage

// ===== src/mqlbm_front.sv =====
// ----------------------------------------------------------------------------
// mqlbm_front
// Accepts requests, checks the handle range and holds them in a short queue.
// ----------------------------------------------------------------------------
module mqlbm_front import mqlbm_pkg::*; #(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] kind,
	input  logic [6:0] queue_handle,
	input  logic [9:0] buffer_index,
	input  logic [1:0] new_queue_type,
	input  logic       param_given,
	input  logic [2:0] new_priority,
	output logic       item_avail,
	output item_t      item,
	input  logic       item_take
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		in_item.kind           = kind;
		in_item.handle         = queue_handle;
		in_item.handle_ok      = (queue_handle != 7'd0) && (int'(queue_handle) <= NUM_QUEUES);
		in_item.buffer_index   = buffer_index;
		in_item.new_queue_type = new_queue_type;
		in_item.param_given    = param_given;
		in_item.new_priority   = new_priority;
	end

	assign full       = (cnt_q == 2'd2);
	assign item_avail = (cnt_q != 2'd0);
	assign item       = ent_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/mqlbm_back.sv =====
// ----------------------------------------------------------------------------
// mqlbm_back
// Carries out create, enqueue and dequeue on the queue tables and link memory.
// ----------------------------------------------------------------------------
module mqlbm_back import mqlbm_pkg::*; #(
	parameter int NUM_QUEUES      = NUM_QUEUES_DEF,
	parameter int NUM_BUFFERS     = NUM_BUFFERS_DEF,
	parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] default_priority,
	input  logic       item_avail,
	input  item_t      item,
	output logic       item_take,
	output logic       empty,
	input  logic       pop,
	output result_t    res
);

	localparam int QW = $clog2(NUM_QUEUES);
	localparam int CW = $clog2(NUM_QUEUES + 1);
	localparam int BW = $clog2(NUM_BUFFERS);
	localparam int PW = $clog2(PRIORITY_LEVELS);

	typedef enum logic [1:0] {S_IDLE, S_LINK, S_EXEC} state_t;

	state_t          state_q;
	item_t           it_q;
	logic [QW-1:0]   idx_q;
	logic [CW-1:0]   alloc_cnt_q;

	logic [1:0]      qstat_q [NUM_QUEUES];
	logic [1:0]      qkind_q [NUM_QUEUES];
	logic [PW-1:0]   qprio_q [NUM_QUEUES];
	logic            qne_q   [NUM_QUEUES];
	logic [1:0]      qst_rd_q;
	logic [1:0]      qkd_rd_q;
	logic [PW-1:0]   qpr_rd_q;
	logic            qne_rd_q;

	logic [BW-1:0]   head_mem [NUM_QUEUES];
	logic [BW-1:0]   tail_mem [NUM_QUEUES];
	logic [BW-1:0]   next_mem [NUM_BUFFERS];
	logic [BW-1:0]   hd_q;
	logic [BW-1:0]   tl_q;
	logic [BW-1:0]   nx_q;

	logic [QW-1:0]   rd_idx;
	logic [QW-1:0]   in_idx;
	result_t         res_q [2];
	logic            rwr_q;
	logic            rrd_q;
	logic [1:0]      rcnt_q;
	logic            rfull;
	logic            exec_go;

	result_t         r;
	logic [BW-1:0]   buf_n;
	logic            head_we;
	logic [BW-1:0]   head_wd;
	logic            tail_we;
	logic            next_we;
	logic            tbl_we;
	logic [QW-1:0]   tbl_idx;
	logic [1:0]      tbl_stat;
	logic            tbl_ne;
	logic            create_we;
	logic [PW-1:0]   create_prio;
	logic [3:0]      prio_raw;
	logic            op_alloc;

	function automatic logic [QW-1:0] to_idx(input logic [6:0] h);
		logic [6:0] hm1;
		hm1 = h - 7'd1;
		return QW'(hm1);
	endfunction

	assign in_idx    = to_idx(item.handle);
	assign rd_idx    = (state_q == S_IDLE) ? in_idx : idx_q;
	assign item_take = (state_q == S_IDLE) && item_avail;
	assign rfull     = (rcnt_q == 2'd2);
	assign exec_go   = (state_q == S_EXEC) && !rfull;
	assign buf_n     = BW'(it_q.buffer_index);
	assign prio_raw  = it_q.param_given ? {1'b0, it_q.new_priority} : {1'b0, default_priority};
	assign create_prio = (int'(prio_raw) >= PRIORITY_LEVELS) ? PW'(PRIORITY_LEVELS - 1)
	                                                         : PW'(prio_raw);
	// Queues are handed out in ascending order and never released, so a
	// queue is allocated exactly when its index is below the allocation count.
	assign op_alloc  = it_q.handle_ok && (CW'(idx_q) < alloc_cnt_q);

	always_comb begin
		r         = '0;
		r.result_handle = it_q.handle;
		head_we   = 1'b0;
		head_wd   = buf_n;
		tail_we   = 1'b0;
		next_we   = 1'b0;
		tbl_we    = 1'b0;
		tbl_idx   = idx_q;
		tbl_stat  = qst_rd_q;
		tbl_ne    = qne_rd_q;
		create_we = 1'b0;
		case (it_q.kind)
			OP_CREATE: begin
				r.result_handle = 7'd0;
				r.op_status     = ST_NO_FREE;
				if (int'(alloc_cnt_q) < NUM_QUEUES) begin
					create_we       = 1'b1;
					tbl_we          = 1'b1;
					tbl_idx         = QW'(alloc_cnt_q);
					tbl_ne          = 1'b0;
					tbl_stat        = (it_q.new_queue_type == TYPE_SCHED ||
					                   it_q.new_queue_type == TYPE_PKTIN)
					                  ? QSTAT_UNSCHED : QSTAT_RUNNABLE;
					r.result_handle = 7'(int'(alloc_cnt_q) + 1);
					r.addressed_type = it_q.new_queue_type;
					r.op_status     = ST_OK;
				end
			end
			OP_ENQUEUE: begin
				if (!op_alloc) begin
					r.op_status = ST_NOT_ALLOC;
				end else begin
					r.addressed_type = qkd_rd_q;
					next_we = qne_rd_q;
					head_we = !qne_rd_q;
					tail_we = 1'b1;
					tbl_we  = 1'b1;
					tbl_ne  = 1'b1;
					if (qst_rd_q == QSTAT_UNSCHED) begin
						tbl_stat            = QSTAT_SCHEDULED;
						r.schedule_request  = 1'b1;
						r.schedule_priority = 3'(qpr_rd_q);
					end
				end
			end
			OP_DEQUEUE: begin
				if (!op_alloc) begin
					r.op_status = ST_NOT_ALLOC;
				end else begin
					r.addressed_type = qkd_rd_q;
					tbl_we = 1'b1;
					if (!qne_rd_q) begin
						r.op_status = ST_EMPTY;
						if (qst_rd_q == QSTAT_SCHEDULED &&
						    qkd_rd_q != TYPE_PKTIN) begin
							tbl_stat = QSTAT_UNSCHED;
						end
					end else begin
						r.out_buffer       = 10'(hd_q);
						r.out_buffer_valid = 1'b1;
						if (hd_q == tl_q) begin
							tbl_ne = 1'b0;
						end else begin
							head_we = 1'b1;
							head_wd = nx_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Head, tail and link memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (exec_go && head_we) begin
			head_mem[idx_q] <= head_wd;
		end
		if (exec_go && tail_we) begin
			tail_mem[idx_q] <= buf_n;
		end
		hd_q <= head_mem[rd_idx];
		tl_q <= tail_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (exec_go && next_we) begin
			next_mem[tl_q] <= buf_n;
		end
		nx_q <= next_mem[hd_q];
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			it_q  <= item;
			idx_q <= in_idx;
		end
		if (exec_go) begin
			res_q[rwr_q] <= r;
		end
	end

	// Queue table: create fills every field of an entry before any other
	// operation may address it, so the table needs no reset.
	always_ff @(posedge clk) begin
		if (exec_go && tbl_we) begin
			qstat_q[tbl_idx] <= tbl_stat;
			qne_q[tbl_idx]   <= tbl_ne;
			if (create_we) begin
				qkind_q[tbl_idx] <= it_q.new_queue_type;
				qprio_q[tbl_idx] <= create_prio;
			end
		end
		qst_rd_q <= qstat_q[rd_idx];
		qkd_rd_q <= qkind_q[rd_idx];
		qpr_rd_q <= qprio_q[rd_idx];
		qne_rd_q <= qne_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alloc_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_avail) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!rfull) begin
						state_q <= S_IDLE;
						if (create_we) begin
							alloc_cnt_q <= alloc_cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result queue.
	assign empty = (rcnt_q == 2'd0);
	assign res   = res_q[rrd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= 1'b0;
			rrd_q  <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			if (exec_go) begin
				rwr_q <= !rwr_q;
			end
			if (pop && !empty) begin
				rrd_q <= !rrd_q;
			end
			case ({exec_go, pop && !empty})
				2'b10:   rcnt_q <= rcnt_q + 2'd1;
				2'b01:   rcnt_q <= rcnt_q - 2'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

endmodule

// ===== src/multi_queue_linked_buffer_manager.sv =====
// ----------------------------------------------------------------------------
// multi_queue_linked_buffer_manager
// Set of FIFO queues of buffer indices linked through one shared link memory.
// ----------------------------------------------------------------------------
// Each request (create, enqueue or dequeue) passes three steps in the
// execution part: a read of the queue's table entry and its head and tail
// memories, a read of the link memory at the head, and a step to compute and
// write back. Requests are accepted into a two-entry queue while earlier ones
// execute, and results wait in a two-entry result queue, so both sides may
// stall independently. Queues are allocated in ascending order and are never
// released, so create needs no search and an allocation count tells which
// queues exist. Every request gives exactly one result. The default priority
// register is always ready and should be written while the block is idle.
// ----------------------------------------------------------------------------
module multi_queue_linked_buffer_manager import mqlbm_pkg::*; #(
	parameter int NUM_QUEUES      = NUM_QUEUES_DEF,
	parameter int NUM_BUFFERS     = NUM_BUFFERS_DEF,
	parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] kind,
	input  logic [6:0] queue_handle,
	input  logic [9:0] buffer_index,
	input  logic [1:0] new_queue_type,
	input  logic       param_given,
	input  logic [2:0] new_priority,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] result_handle,
	output logic [9:0] out_buffer,
	output logic       out_buffer_valid,
	output logic       schedule_request,
	output logic [2:0] schedule_priority,
	output logic [1:0] addressed_type,
	output logic [1:0] op_status
);

	logic [2:0] default_priority_q;
	logic       item_avail;
	logic       item_take;
	item_t      item;
	result_t    res;

	// The configuration register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_priority_q <= DEFAULT_PRIORITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			default_priority_q <= cfg_data;
		end
	end

	mqlbm_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.queue_handle   (queue_handle),
		.buffer_index   (buffer_index),
		.new_queue_type (new_queue_type),
		.param_given    (param_given),
		.new_priority   (new_priority),
		.item_avail     (item_avail),
		.item           (item),
		.item_take      (item_take)
	);

	mqlbm_back #(
		.NUM_QUEUES      (NUM_QUEUES),
		.NUM_BUFFERS     (NUM_BUFFERS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.default_priority (default_priority_q),
		.item_avail       (item_avail),
		.item             (item),
		.item_take        (item_take),
		.empty            (empty),
		.pop              (pop),
		.res              (res)
	);

	assign result_handle     = res.result_handle;
	assign out_buffer        = res.out_buffer;
	assign out_buffer_valid  = res.out_buffer_valid;
	assign schedule_request  = res.schedule_request;
	assign schedule_priority = res.schedule_priority;
	assign addressed_type    = res.addressed_type;
	assign op_status         = res.op_status;

`ifndef SYNTHESIS
	// A returned buffer always comes with a good status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_buffer_valid) |-> (op_status == ST_OK))
		else $error("buffer returned with a failing status");

	// A failed handle check neither returns a buffer nor asks for scheduling.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && op_status == ST_NOT_ALLOC) |-> (!out_buffer_valid && !schedule_request))
		else $error("unallocated queue produced a side effect");

	// A schedule request only follows a successful enqueue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && schedule_request) |-> (op_status == ST_OK && !out_buffer_valid))
		else $error("schedule request on a non-enqueue result");
`endif

endmodule
